// ===== hdl/fkde_pkg.sv =====
// ----------------------------------------------------------------------------
// fkde_pkg: shared types and constants for four_key_debounce_events
// Request payload structs, threshold register indexes and reset values.
// ----------------------------------------------------------------------------
package fkde_pkg;

  localparam int COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // threshold reset values
  localparam logic [COUNT_W-1:0] ONOFF_THR_RST   = 8'd8;
  localparam logic [COUNT_W-1:0] SHOCK_THR_RST   = 8'd2;
  localparam logic [COUNT_W-1:0] COVER_THR_RST   = 8'd16;
  localparam logic [COUNT_W-1:0] PATIENT_THR_RST = 8'd3;

  typedef enum logic [1:0] {
    REG_ONOFF_THR   = 2'd0,
    REG_SHOCK_THR   = 2'd1,
    REG_COVER_THR   = 2'd2,
    REG_PATIENT_THR = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic onoff_level;
    logic shock_level;
    logic cover_level;
    logic patient_level;
  } tick_t;

  typedef struct packed {
    logic onoff_event;
    logic shock_event;
    logic cover_event;
    logic patient_event;
  } events_t;

endpackage

// ===== hdl/fkde_repeat_key.sv =====
// ----------------------------------------------------------------------------
// fkde_repeat_key: repeat-counter key
// Counts held ticks, fires and clears at threshold, clears on release.
// ----------------------------------------------------------------------------
module fkde_repeat_key
  import fkde_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               level,
  input  logic [COUNT_W-1:0] threshold,
  output logic               fire
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_mid;
  logic [COUNT_W-1:0] count_next;

  always_comb begin
    if (level) begin
      count_mid = (count != COUNT_MAX) ? count + COUNT_W'(1) : count;
    end else begin
      count_mid = '0;
    end
    fire       = (count_mid >= threshold);
    count_next = fire ? '0 : count_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step) begin
      count <= count_next;
    end
  end

endmodule

// ===== hdl/fkde_latch_key.sv =====
// ----------------------------------------------------------------------------
// fkde_latch_key: release-latched key
// One event per press; rearms once the counter has run back to zero.
// ----------------------------------------------------------------------------
module fkde_latch_key
  import fkde_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               level,
  input  logic [COUNT_W-1:0] threshold,
  output logic               fire
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               armed;
  logic               armed_mid;
  logic               armed_next;

  always_comb begin
    if (level) begin
      // grow only while armed, saturate at top
      count_next = (armed && count != COUNT_MAX) ? count + COUNT_W'(1) : count;
      armed_mid  = armed;
    end else begin
      count_next = (count != '0) ? count - COUNT_W'(1) : count;
      armed_mid  = armed | (count_next == '0);
    end
    fire       = armed_mid && (count_next == threshold);
    armed_next = armed_mid & ~fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      armed <= 1'b1;
    end else if (step) begin
      count <= count_next;
      armed <= armed_next;
    end
  end

endmodule

// ===== hdl/four_key_debounce_events.sv =====
// ----------------------------------------------------------------------------
// four_key_debounce_events: four-key debounce and event block
// Per-tick debounce of on-off, shock, cover and patient-type keys.
// ----------------------------------------------------------------------------
// Each accepted tick request carries four key levels and yields exactly one
// event request with four one-tick flags. The block takes one tick per clock
// cycle when tick_stall is low: key updates and threshold compares happen in
// the accept cycle, and the flags land in a single output register in the
// next cycle. tick_stall is raised only while that register holds a request
// the downstream side is stalling, so a full register that drains in the same
// cycle still lets the next tick in. Shock and cover use repeat counters
// (held key fires every threshold ticks); on-off and patient-type use a
// release latch (one event per press, rearmed after the count runs back to
// zero). Thresholds are written through the cfg port, which is always ready;
// write them only while no tick is in flight. An index past the list has no
// effect (index is 2 bits, so all codes map to a register).
// ----------------------------------------------------------------------------
module four_key_debounce_events
  import fkde_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // tick requests
  input  logic               tick_valid,
  output logic               tick_stall,
  input  tick_t              tick,
  // event requests
  output logic               event_valid,
  input  logic               event_stall,
  output events_t            events,
  // threshold writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] onoff_thr;
  logic [COUNT_W-1:0] shock_thr;
  logic [COUNT_W-1:0] cover_thr;
  logic [COUNT_W-1:0] patient_thr;

  logic    accept;
  events_t fire;

  // output register may be refilled whenever it is empty or draining
  assign tick_stall = event_valid & event_stall;
  assign accept     = tick_valid & ~tick_stall;
  assign cfg_ready  = 1'b1;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      onoff_thr   <= ONOFF_THR_RST;
      shock_thr   <= SHOCK_THR_RST;
      cover_thr   <= COVER_THR_RST;
      patient_thr <= PATIENT_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ONOFF_THR:   onoff_thr   <= cfg_data;
        REG_SHOCK_THR:   shock_thr   <= cfg_data;
        REG_COVER_THR:   cover_thr   <= cfg_data;
        REG_PATIENT_THR: patient_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  fkde_latch_key u_onoff (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .level     (tick.onoff_level),
    .threshold (onoff_thr),
    .fire      (fire.onoff_event)
  );

  fkde_repeat_key u_shock (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .level     (tick.shock_level),
    .threshold (shock_thr),
    .fire      (fire.shock_event)
  );

  fkde_repeat_key u_cover (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .level     (tick.cover_level),
    .threshold (cover_thr),
    .fire      (fire.cover_event)
  );

  fkde_latch_key u_patient (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .level     (tick.patient_level),
    .threshold (patient_thr),
    .fire      (fire.patient_event)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (accept) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      events <= fire;
    end
  end

  // every accepted tick leaves a result waiting
  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> event_valid)
    else $error("accepted tick produced no event request");

  // released repeat key only fires at threshold zero
  a_shock_release: assert property (@(posedge clk) disable iff (rst)
    (accept && !tick.shock_level && shock_thr != '0) |=> !events.shock_event)
    else $error("shock event on released key");

  a_cover_release: assert property (@(posedge clk) disable iff (rst)
    (accept && !tick.cover_level && cover_thr != '0) |=> !events.cover_event)
    else $error("cover event on open switch");

endmodule
